// File: rtl/cfrd_pkg.sv
// ----------------------------------------------------------------------------
// cfrd_pkg
// Shared types and constants for the CAN receive frame queue.
// ----------------------------------------------------------------------------
package cfrd_pkg;

   // Item kinds on the request channel
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam int REQ_DATA_W = 96;   // bus, can_id, length, payload, zero pad
   localparam int RSP_DATA_W = 128;  // bus, id, length, payload, drop total, zero pad
   localparam int ENTRY_W    = 92;   // stored frame: {payload, length, can_id, bus}
   localparam int DROP_W     = 32;

   localparam logic [3:0] LEN_MAX       = 4'd8;
   localparam logic [4:0] BUDGET_RESET  = 5'd8;
   localparam logic [4:0] BUDGET_MAX    = 5'd16;

   typedef enum logic [1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_DROPPED   = 2'd1,
      ST_DELIVERED = 2'd2,
      ST_EMPTY     = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic busy;
   } queue_stat_type;

endpackage

// File: rtl/cfrd_ram.sv
// ----------------------------------------------------------------------------
// cfrd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cfrd_ctrl.sv
// ----------------------------------------------------------------------------
// cfrd_ctrl
// Queue control: pointers, drop counter, drain sequencer and result register.
// ----------------------------------------------------------------------------
module cfrd_ctrl
   import cfrd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [3:0]            budget_lim,   // frames per tick, minus one
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  ram_wr_en,
   output logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_wr_addr,
   output logic [ENTRY_W-1:0]    ram_wr_data,
   output logic                  ram_rd_en,
   output logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_rd_addr,
   input  logic [ENTRY_W-1:0]    ram_rd_data,
   output queue_stat_type        stat
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic                  wr_ph_ff, wr_ph_in, rd_ph_ff, rd_ph_in;
   logic [DROP_W-1:0]     drop_cnt_ff, drop_cnt_in;
   logic [3:0]            cnt_ff, cnt_in, lim_ff, lim_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_status_type        rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free, req_fire, full, empty, last_emit;
   logic [SLOT_W-1:0]     wr_slot_nx, rd_slot_nx;
   logic                  wr_ph_nx, rd_ph_nx;
   logic [3:0]            len_clamp;
   logic [63:0]           pay_masked;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;
   assign full     = (wr_slot_ff == rd_slot_ff) && (wr_ph_ff != rd_ph_ff);
   assign empty    = (wr_slot_ff == rd_slot_ff) && (wr_ph_ff == rd_ph_ff);

   assign wr_slot_nx = (wr_slot_ff == SLOT_LAST) ? '0 : wr_slot_ff + 1'b1;
   assign wr_ph_nx   = (wr_slot_ff == SLOT_LAST) ? !wr_ph_ff : wr_ph_ff;
   assign rd_slot_nx = (rd_slot_ff == SLOT_LAST) ? '0 : rd_slot_ff + 1'b1;
   assign rd_ph_nx   = (rd_slot_ff == SLOT_LAST) ? !rd_ph_ff : rd_ph_ff;

   // Stop on budget or when the queue runs dry
   assign last_emit = (cnt_ff == lim_ff) ||
                      ((rd_slot_nx == wr_slot_ff) && (rd_ph_nx == wr_ph_ff));

   // Clamp length and zero bytes beyond it
   always_comb begin
      len_clamp = (req_tdata[27:24] > LEN_MAX) ? LEN_MAX : req_tdata[27:24];
      for (int b = 0; b < 8; b++) begin
         pay_masked[b*8 +: 8] = (4'(b) < len_clamp) ? req_tdata[28 + b*8 +: 8] : 8'h00;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == KIND_TICK && !empty) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_EMIT;
         S_EMIT: begin
            if (out_free && last_emit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_tready    = (state_ff == S_IDLE) && out_free;
      wr_slot_in    = wr_slot_ff;
      wr_ph_in      = wr_ph_ff;
      rd_slot_in    = rd_slot_ff;
      rd_ph_in      = rd_ph_ff;
      drop_cnt_in   = drop_cnt_ff;
      cnt_in        = cnt_ff;
      lim_in        = lim_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_slot_ff;
      ram_wr_data   = {pay_masked, len_clamp, req_tdata[23:0]};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (req_tuser == KIND_FRAME) begin
                  if (full) begin
                     drop_cnt_in   = drop_cnt_ff + 1'b1;
                     rsp_status_in = ST_DROPPED;
                  end else begin
                     ram_wr_en     = 1'b1;
                     wr_slot_in    = wr_slot_nx;
                     wr_ph_in      = wr_ph_nx;
                     rsp_status_in = ST_ACCEPTED;
                  end
                  rsp_data_in = {{(RSP_DATA_W - DROP_W - ENTRY_W){1'b0}},
                                 drop_cnt_in, {ENTRY_W{1'b0}}};
               end else if (empty) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_data_in   = {{(RSP_DATA_W - DROP_W - ENTRY_W){1'b0}},
                                   drop_cnt_ff, {ENTRY_W{1'b0}}};
               end else begin
                  // Start a drain: no result yet, fetch the oldest frame
                  rsp_valid_in = 1'b0;
                  ram_rd_en    = 1'b1;
                  cnt_in       = '0;
                  lim_in       = budget_lim;
               end
            end
         end
         S_FETCH: ;
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DELIVERED;
               rsp_last_in   = last_emit;
               rsp_data_in   = {{(RSP_DATA_W - DROP_W - ENTRY_W){1'b0}},
                                drop_cnt_ff, ram_rd_data};
               rd_slot_in    = rd_slot_nx;
               rd_ph_in      = rd_ph_nx;
               cnt_in        = cnt_ff + 1'b1;
               // Prefetch the next frame so one leaves each cycle while the output is not stalled
               ram_rd_en     = !last_emit;
               ram_rd_addr   = rd_slot_nx;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_slot_ff   <= '0;
         wr_ph_ff     <= 1'b0;
         rd_slot_ff   <= '0;
         rd_ph_ff     <= 1'b0;
         drop_cnt_ff  <= '0;
         cnt_ff       <= '0;
         lim_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_slot_ff   <= wr_slot_in;
         wr_ph_ff     <= wr_ph_in;
         rd_slot_ff   <= rd_slot_in;
         rd_ph_ff     <= rd_ph_in;
         drop_cnt_ff  <= drop_cnt_in;
         cnt_ff       <= cnt_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign stat.full  = full;
   assign stat.empty = empty;
   assign stat.busy  = (state_ff != S_IDLE);

endmodule

// File: rtl/can_frame_rx_fifo_drain.sv
// ----------------------------------------------------------------------------
// can_frame_rx_fifo_drain
// Ring queue of received CAN frames with budgeted draining on service ticks.
// ----------------------------------------------------------------------------
// A receive item (req_tuser = 0) stores one frame, or drops it and bumps the
// wrapping drop counter when the queue is full; it gives one result in the
// cycle after acceptance. A service tick (req_tuser = 1) on an empty queue
// gives one "empty" result the same way. A tick that finds n frames
// (n = min(occupancy, budget)) delivers them oldest first, tlast on the
// final one: the first frame passes through the frame memory's registered
// read, an idle fetch state and the result register, then one frame per
// cycle follows while rsp_tready stays high. Frames live in a single memory
// of QUEUE_DEPTH entries with one write and one read port. The drain budget
// written through csr_ is clamped to 1..16.
// ----------------------------------------------------------------------------
module can_frame_rx_fifo_drain
   import cfrd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [4:0]            csr_wr_data,  // drain_budget
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // bus[7:0], can_id[23:8], length[27:24],
                                               // payload[91:28], zero[95:92]
   input  logic                  req_tuser,    // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // out_bus[7:0], out_id[23:8],
                                               // out_length[27:24], out_payload[91:28],
                                               // dropped_total[123:92], zero[127:124]
   output logic [1:0]            rsp_tuser,    // status
   output logic                  rsp_tlast     // last
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [4:0]         budget_ff, budget_in;
   logic [3:0]         budget_lim;
   logic               ram_wr_en, ram_rd_en;
   logic [SLOT_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
   queue_stat_type     stat;

   assign budget_in = csr_wr_en ? csr_wr_data : budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else begin
         budget_ff <= budget_in;
      end
   end

   // Clamp to 1..16 and hold as count minus one
   always_comb begin
      priority if (budget_ff == 5'd0) begin
         budget_lim = 4'd0;
      end else if (budget_ff > BUDGET_MAX) begin
         budget_lim = 4'd15;
      end else begin
         budget_lim = 4'(budget_ff - 5'd1);
      end
   end

   cfrd_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .budget_lim  (budget_lim),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .stat        (stat)
   );

   cfrd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   a_full_empty_excl: assert property (@(posedge clock) disable iff (reset)
      !(stat.full && stat.empty))
      else $error("queue reports full and empty at once");

   a_drop_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_FRAME && stat.full
      |=> rsp_tvalid && rsp_tuser == ST_DROPPED && rsp_tlast)
      else $error("frame into full queue did not give a drop result");

   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_TICK && stat.empty
      |=> rsp_tvalid && rsp_tuser == ST_EMPTY && rsp_tlast && !stat.busy)
      else $error("tick on empty queue did not give an empty result");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !ram_wr_en)
      else $error("frame memory written during a drain");

endmodule
